[design/lwd_pkg.sv]
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Shared widths, constants, codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package lwd_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned SIZE_W         = 24;
  localparam int unsigned WIN_DEPTH      = 4096;
  localparam int unsigned WIN_AW         = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W         = WIN_AW + 1;
  localparam int unsigned LEN_W          = 5;
  localparam int unsigned FLAG_CNT_W     = 4;
  localparam int unsigned FLAGS_PER_CTRL = 8;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [WIN_AW-1:0] START_POSITION = WIN_AW'(4078);
  localparam logic [BYTE_W-1:0] SPACE_BYTE     = 8'h20;
  localparam logic [LEN_W-1:0]  MIN_MATCH      = LEN_W'(3);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_OVERRUN   = 2'd2
  } status_e;

  // What the next compressed byte is taken as.
  typedef enum logic [1:0] {
    PH_CTRL     = 2'd0,
    PH_TOKEN    = 2'd1,
    PH_MATCH_HI = 2'd2
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic capture;
    logic start_blk;
    logic reject;
    logic ctrl_load;
    logic literal;
    logic match_low;
    logic match_setup;
    logic read;
    logic copy;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic   in_valid;
    logic   start;
    logic   zero_size;
    logic   remaining_zero;
    phase_e phase;
    logic   flag_bit;
    logic   copy_last;
    logic   out_free;
  } stat_t;

endpackage

[design/lwd_if.sv]
// ----------------------------------------------------------------------------
// LZSS window decompressor stream interfaces
// Valid/ready channels for compressed input words and decompressed words.
// ----------------------------------------------------------------------------
interface lwd_in_if;
  import lwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              block_start;

  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface lwd_out_if;
  import lwd_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                last_of_run;
  logic                block_done;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output out_byte, output last_of_run,
                  output block_done, output status, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input block_done, input status, output ready);
endinterface

[design/lzss_window_decompressor_unit.sv]
// A literal word is decoded after capture and goes to the output register once
// that is free. Each match byte takes a window read, then an emit. Control and
// match low words are captured, then decoded; at most one word is in work.
// Throughput is set by the read and emit steps of each match byte and by output
// register stalls. Reset clears all control state; the window needs no clearing,
// because a fill count makes entries unwritten since block start read as spaces.
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Decodes an LZSS stream with a 4096-byte history into one byte per word.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       expected_size_we_i,
  input  logic [lwd_pkg::SIZE_W-1:0] expected_size_i,
  lwd_in_if.sink                     in_i,
  lwd_out_if.source                  out_o
);
  import lwd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  lwd_controller u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // Token state, window and output register.
  lwd_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .expected_size_we_i(expected_size_we_i),
    .expected_size_i   (expected_size_i),
    .in_i              (in_i),
    .out_o             (out_o)
  );

endmodule

[design/lwd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/lwd_datapath.sv]
// ----------------------------------------------------------------------------
// LZSS window decompressor datapath
// Token state, history window with fill count, match copy counters and the
// output word register.
// ----------------------------------------------------------------------------
module lwd_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lwd_pkg::cmd_t             cmd_i,
  output lwd_pkg::stat_t            stat_o,
  input  logic                      expected_size_we_i,
  input  logic [lwd_pkg::SIZE_W-1:0] expected_size_i,
  lwd_in_if.sink                    in_i,
  lwd_out_if.source                 out_o
);
  import lwd_pkg::*;

  // Control state.
  logic [SIZE_W-1:0]     expected_q, expected_d;
  logic [SIZE_W-1:0]     remaining_q, remaining_d;
  logic [WIN_AW-1:0]     wp_q, wp_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [BYTE_W-1:0]     flag_bits_q, flag_bits_d;
  logic [FLAG_CNT_W-1:0] flags_left_q, flags_left_d;
  phase_e                phase_q, phase_d;
  logic [LEN_W-1:0]      copy_left_q, copy_left_d;
  logic                  out_valid_q, out_valid_d;

  // Payload state.
  logic [BYTE_W-1:0]     in_byte_q, in_byte_d;
  logic                  in_start_q, in_start_d;
  logic [BYTE_W-1:0]     low_q, low_d;
  logic [WIN_AW-1:0]     copy_addr_q, copy_addr_d;
  logic                  cut_q, cut_d;
  logic                  rd_ok_q, rd_ok_d;
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;
  logic                  out_last_q, out_last_d;
  logic                  out_done_q, out_done_d;
  status_e               out_status_q, out_status_d;

  // Window port and helpers.
  logic                  win_we;
  logic [BYTE_W-1:0]     win_wdata;
  logic [BYTE_W-1:0]     win_rdata;
  logic [BYTE_W-1:0]     copy_byte;
  logic [WIN_AW-1:0]     match_dist;
  logic [WIN_AW-1:0]     rd_offset;
  logic [LEN_W-1:0]      match_len;
  logic                  match_cut;
  logic [FILL_W-1:0]     fill_inc;
  logic                  out_free;

  lwd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WIN_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(wp_q),
    .wdata_i(win_wdata),
    .re_i   (cmd_i.read),
    .raddr_i(copy_addr_q),
    .rdata_o(win_rdata)
  );

  // Entries not yet written since the block started read as spaces.
  assign copy_byte = rd_ok_q ? win_rdata : SPACE_BYTE;
  assign win_we    = cmd_i.literal | cmd_i.copy;
  assign win_wdata = cmd_i.literal ? in_byte_q : copy_byte;

  // Match decode from the high byte and the stored low byte.
  assign match_dist = {in_byte_q[7:4], low_q};
  assign match_len = LEN_W'(in_byte_q[3:0]) + MIN_MATCH;
  assign match_cut = SIZE_W'(match_len) > remaining_q;
  assign rd_offset = copy_addr_q - START_POSITION;
  assign fill_inc  = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + FILL_W'(1);
  assign out_free  = !out_valid_q || out_o.ready;

  // Next-state logic.
  always_comb begin
    expected_d   = expected_q;
    remaining_d  = remaining_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    phase_d      = phase_q;
    copy_left_d  = copy_left_q;
    out_valid_d  = out_valid_q;
    in_byte_d    = in_byte_q;
    in_start_d   = in_start_q;
    low_d        = low_q;
    copy_addr_d  = copy_addr_q;
    cut_d        = cut_q;
    rd_ok_d      = rd_ok_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    out_status_d = out_status_q;

    if (expected_size_we_i) begin
      expected_d = expected_size_i;
    end
    if (cmd_i.capture) begin
      in_byte_d  = in_i.in_byte;
      in_start_d = in_i.block_start;
    end

    // A new block clears the token state and the window fill count.
    if (cmd_i.start_blk) begin
      wp_d         = START_POSITION;
      fill_d       = '0;
      flag_bits_d  = '0;
      flags_left_d = '0;
      phase_d      = PH_CTRL;
      remaining_d  = expected_q;
    end
    if (cmd_i.ctrl_load) begin
      flag_bits_d  = in_byte_q;
      flags_left_d = FLAG_CNT_W'(FLAGS_PER_CTRL);
      phase_d      = PH_TOKEN;
    end

    // Each token start uses up one flag.
    if (cmd_i.literal || cmd_i.match_low) begin
      flag_bits_d  = flag_bits_q >> 1;
      flags_left_d = flags_left_q - FLAG_CNT_W'(1);
    end
    if (cmd_i.literal) begin
      phase_d = (flags_left_q == FLAG_CNT_W'(1)) ? PH_CTRL : PH_TOKEN;
    end
    if (cmd_i.match_low) begin
      low_d   = in_byte_q;
      phase_d = PH_MATCH_HI;
    end

    // Match set-up clips the length to the bytes still owed.
    if (cmd_i.match_setup) begin
      copy_addr_d = wp_q - match_dist;
      copy_left_d = match_cut ? remaining_q[LEN_W-1:0] : match_len;
      cut_d       = match_cut;
      phase_d     = (flags_left_q == '0) ? PH_CTRL : PH_TOKEN;
    end
    if (cmd_i.read) begin
      rd_ok_d = {1'b0, rd_offset} < fill_q;
    end

    // Every literal and copy byte goes into the window.
    if (cmd_i.literal || cmd_i.copy) begin
      wp_d        = wp_q + WIN_AW'(1);
      fill_d      = fill_inc;
      remaining_d = remaining_q - SIZE_W'(1);
    end
    if (cmd_i.copy) begin
      copy_addr_d = copy_addr_q + WIN_AW'(1);
      copy_left_d = copy_left_q - LEN_W'(1);
    end

    // Output word register.
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.reject) begin
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      out_last_d   = 1'b1;
      out_done_d   = 1'b1;
      out_status_d = ST_ZERO_SIZE;
    end else if (cmd_i.literal) begin
      out_valid_d  = 1'b1;
      out_byte_d   = in_byte_q;
      out_last_d   = 1'b1;
      out_done_d   = (remaining_q == SIZE_W'(1));
      out_status_d = ST_OK;
    end else if (cmd_i.copy) begin
      out_valid_d  = 1'b1;
      out_byte_d   = copy_byte;
      out_last_d   = (copy_left_q == LEN_W'(1));
      out_done_d   = (remaining_q == SIZE_W'(1));
      out_status_d = (cut_q && copy_left_q == LEN_W'(1)) ? ST_OVERRUN : ST_OK;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= '0;
      remaining_q  <= '0;
      wp_q         <= START_POSITION;
      fill_q       <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      phase_q      <= PH_CTRL;
      copy_left_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      expected_q   <= expected_d;
      remaining_q  <= remaining_d;
      wp_q         <= wp_d;
      fill_q       <= fill_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      phase_q      <= phase_d;
      copy_left_q  <= copy_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_byte_q    <= in_byte_d;
    in_start_q   <= in_start_d;
    low_q        <= low_d;
    copy_addr_q  <= copy_addr_d;
    cut_q        <= cut_d;
    rd_ok_q      <= rd_ok_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_done_q   <= out_done_d;
    out_status_q <= out_status_d;
  end

  // Ports and status.
  assign in_i.ready         = cmd_i.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.last_of_run  = out_last_q;
  assign out_o.block_done   = out_done_q;
  assign out_o.status       = out_status_q;

  assign stat_o.in_valid       = in_i.valid;
  assign stat_o.start          = in_start_q;
  assign stat_o.zero_size      = (expected_q == '0);
  assign stat_o.remaining_zero = (remaining_q == '0);
  assign stat_o.phase          = phase_q;
  assign stat_o.flag_bit       = flag_bits_q[0];
  assign stat_o.copy_last      = (copy_left_q == LEN_W'(1));
  assign stat_o.out_free       = out_free;

`ifndef ASSERT_OFF
  // The fill count saturates at the window size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("window fill count beyond window size");

  // A match never owes more bytes than the block still has.
  a_match_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.match_setup |=> (copy_left_q != '0) && (SIZE_W'(copy_left_q) <= remaining_q))
    else $error("match length not clipped to remaining byte count");

  // No byte is produced once the block is complete.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.literal || cmd_i.copy) |-> (remaining_q != '0))
    else $error("byte emitted after block completion");
`endif

endmodule

[design/lwd_controller.sv]
// ----------------------------------------------------------------------------
// LZSS window decompressor controller
// Sequences word capture, token decode and the read/emit loop of a match.
// ----------------------------------------------------------------------------
module lwd_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lwd_pkg::stat_t stat_i,
  output lwd_pkg::cmd_t  cmd_o
);
  import lwd_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE   = 2'd0,
    C_DECODE = 2'd1,
    C_READ   = 2'd2,
    C_EMIT   = 2'd3
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  cmd_t        cmd;

  // Command decode and next state.
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd.capture = 1'b1;
          state_d     = C_DECODE;
        end
      end
      C_DECODE: begin
        if (stat_i.start) begin
          if (stat_i.zero_size) begin
            // The rejection word waits for a free output register.
            if (stat_i.out_free) begin
              cmd.start_blk = 1'b1;
              cmd.reject    = 1'b1;
              state_d       = C_IDLE;
            end
          end else begin
            cmd.start_blk = 1'b1;
            cmd.ctrl_load = 1'b1;
            state_d       = C_IDLE;
          end
        end else if (stat_i.remaining_zero) begin
          state_d = C_IDLE;
        end else begin
          case (stat_i.phase)
            PH_TOKEN: begin
              if (stat_i.flag_bit) begin
                if (stat_i.out_free) begin
                  cmd.literal = 1'b1;
                  state_d     = C_IDLE;
                end
              end else begin
                cmd.match_low = 1'b1;
                state_d       = C_IDLE;
              end
            end
            PH_MATCH_HI: begin
              cmd.match_setup = 1'b1;
              state_d         = C_READ;
            end
            default: begin
              cmd.ctrl_load = 1'b1;
              state_d       = C_IDLE;
            end
          endcase
        end
      end
      C_READ: begin
        cmd.read = 1'b1;
        state_d  = C_EMIT;
      end
      C_EMIT: begin
        if (stat_i.out_free) begin
          cmd.copy = 1'b1;
          state_d  = stat_i.copy_last ? C_IDLE : C_READ;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

`ifndef ASSERT_OFF
  // A result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.reject || cmd.literal || cmd.copy) |-> stat_i.out_free)
    else $error("output register overwritten");

  // Copy bytes are emitted only after a window read.
  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_EMIT) |-> ($past(state_q) == C_READ || $past(state_q) == C_EMIT))
    else $error("copy emit without a preceding window read");
`endif

endmodule
